/* hw/rtl/tftc_pkg.sv */
// Shared types and constants for the traffic flow template classifier.
`default_nettype none

package tftc_pkg;

  localparam int unsigned IdxOutW = 4;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef struct packed {
    logic [1:0]  direction;
    logic [31:0] remote_address;
    logic [31:0] remote_mask;
    logic [31:0] local_address;
    logic [31:0] local_mask;
    logic [15:0] remote_port_start;
    logic [15:0] remote_port_end;
    logic [15:0] local_port_start;
    logic [15:0] local_port_end;
    logic [7:0]  tos;
    logic [7:0]  tos_mask;
  } filter_t;

  typedef struct packed {
    logic load;
    logic add_exec;
    logic scan_issue;
    logic scan_eval;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic full;
    logic empty;
    logic more;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/tftc_ctrl.sv */
// Controller state machine that sequences adds and filter table scans.
`default_nettype none

module tftc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire tftc_pkg::sts_t sts_i,
  output tftc_pkg::cmd_t     cmd_o
);
  import tftc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.add_exec    = (state_q == ST_DECODE) && sts_i.is_add;
    cmd_o.scan_issue  = ((state_q == ST_DECODE) && !sts_i.is_add && !sts_i.empty) ||
                        ((state_q == ST_SCAN) && sts_i.more);
    cmd_o.scan_eval   = (state_q == ST_SCAN);
    cmd_o.result_load = (state_q == ST_RESP) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((state_q == ST_RESP) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          if (sts_i.is_add || sts_i.empty) begin
            state_q <= ST_RESP;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!sts_i.more) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  a_result_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESP))
    else $error("result raised outside the response state");

  a_scan_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> $past(cmd_o.scan_issue))
    else $error("scan state entered without an issued read");

endmodule

`default_nettype wire

/* hw/rtl/tftc_dp.sv */
// Datapath: item registers, filter memory, match logic and result registers.
`default_nettype none

module tftc_dp #(
  parameter int unsigned MAX_FILTERS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tftc_pkg::cmd_t cmd_i,
  output tftc_pkg::sts_t     sts_o,
  input  wire logic          operation_i,
  input  wire logic [1:0]    direction_i,
  input  wire logic [31:0]   remote_address_i,
  input  wire logic [31:0]   remote_mask_i,
  input  wire logic [31:0]   local_address_i,
  input  wire logic [31:0]   local_mask_i,
  input  wire logic [15:0]   remote_port_low_i,
  input  wire logic [15:0]   remote_port_high_i,
  input  wire logic [15:0]   local_port_low_i,
  input  wire logic [15:0]   local_port_high_i,
  input  wire logic [7:0]    tos_value_i,
  input  wire logic [7:0]    tos_mask_i,
  output logic               matched_o,
  output logic [tftc_pkg::IdxOutW-1:0] filter_index_o,
  output logic               table_full_o
);
  import tftc_pkg::*;

  localparam int unsigned IdxW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_FILTERS + 1);

  filter_t               mem_q [MAX_FILTERS];
  filter_t               rd_q;
  filter_t               item_q;
  logic                  op_q;
  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       ptr_q;
  logic                  hit_q;
  logic                  add_full_q;
  logic [IdxOutW-1:0]    add_idx_q;
  logic                  matched_q;
  logic [IdxOutW-1:0]    index_q;
  logic                  full_q;
  logic                  slot_hit;
  logic [CntW+IdxOutW-1:0] count_ext;

  assign sts_o.is_add = (op_q == OP_ADD);
  assign sts_o.full   = (count_q == CntW'(MAX_FILTERS));
  assign sts_o.empty  = (count_q == '0);
  assign sts_o.more   = (ptr_q < count_q);

  assign count_ext = {{IdxOutW{1'b0}}, count_q};

  assign slot_hit = ((item_q.direction & rd_q.direction) != 2'b00) &&
    ((item_q.remote_address & rd_q.remote_mask) ==
     (rd_q.remote_address & rd_q.remote_mask)) &&
    ((item_q.local_address & rd_q.local_mask) ==
     (rd_q.local_address & rd_q.local_mask)) &&
    (item_q.remote_port_start >= rd_q.remote_port_start) &&
    (item_q.remote_port_start <= rd_q.remote_port_end) &&
    (item_q.local_port_start >= rd_q.local_port_start) &&
    (item_q.local_port_start <= rd_q.local_port_end) &&
    ((item_q.tos & rd_q.tos_mask) == (rd_q.tos & rd_q.tos_mask));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q                     <= operation_i;
      item_q.direction         <= direction_i;
      item_q.remote_address    <= remote_address_i;
      item_q.remote_mask       <= remote_mask_i;
      item_q.local_address     <= local_address_i;
      item_q.local_mask        <= local_mask_i;
      item_q.remote_port_start <= remote_port_low_i;
      item_q.remote_port_end   <= remote_port_high_i;
      item_q.local_port_start  <= local_port_low_i;
      item_q.local_port_end    <= local_port_high_i;
      item_q.tos               <= tos_value_i;
      item_q.tos_mask          <= tos_mask_i;
    end
    if (cmd_i.add_exec && !sts_o.full) begin
      mem_q[count_q[IdxW-1:0]] <= item_q;
    end
    if (cmd_i.scan_issue) begin
      rd_q <= mem_q[ptr_q[IdxW-1:0]];
    end
    if (cmd_i.add_exec) begin
      add_full_q <= sts_o.full;
      add_idx_q  <= sts_o.full ? '0 : count_ext[IdxOutW-1:0];
    end
    if (cmd_i.result_load) begin
      matched_q <= !sts_o.is_add && hit_q;
      index_q   <= sts_o.is_add ? add_idx_q : '0;
      full_q    <= sts_o.is_add && add_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        ptr_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          ptr_q <= ptr_q + 1'b1;
        end
        if (cmd_i.scan_eval && slot_hit) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.add_exec && !sts_o.full) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  assign matched_o      = matched_q;
  assign filter_index_o = index_q;
  assign table_full_o   = full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_FILTERS))
    else $error("filter count exceeds the table size");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= count_q)
    else $error("scan pointer passed the filter count");

  a_full_add_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_exec && sts_o.full |=> $stable(count_q))
    else $error("rejected add changed the filter count");

endmodule

`default_nettype wire

/* hw/rtl/traffic_flow_template_classifier_unit.sv */
// Top level of the traffic flow template classifier.
// An add beat passes from acceptance through the decode and response states to a
// registered result; a classify beat also scans the N stored filters in between, as
// the filter memory delivers one filter per cycle. One beat is in flight at a time,
// and the response state holds while a registered result still waits for the receiver.
// Reset empties the filter table; filter contents are not cleared.
`default_nettype none

module traffic_flow_template_classifier_unit #(
  parameter int unsigned MAX_FILTERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [1:0]  direction_i,
  input  wire logic [31:0] remote_address_i,
  input  wire logic [31:0] remote_mask_i,
  input  wire logic [31:0] local_address_i,
  input  wire logic [31:0] local_mask_i,
  input  wire logic [15:0] remote_port_low_i,
  input  wire logic [15:0] remote_port_high_i,
  input  wire logic [15:0] local_port_low_i,
  input  wire logic [15:0] local_port_high_i,
  input  wire logic [7:0]  tos_value_i,
  input  wire logic [7:0]  tos_mask_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             matched_o,
  output logic [tftc_pkg::IdxOutW-1:0] filter_index_o,
  output logic             table_full_o
);
  import tftc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tftc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tftc_dp #(
    .MAX_FILTERS (MAX_FILTERS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .operation_i        (operation_i),
    .direction_i        (direction_i),
    .remote_address_i   (remote_address_i),
    .remote_mask_i      (remote_mask_i),
    .local_address_i    (local_address_i),
    .local_mask_i       (local_mask_i),
    .remote_port_low_i  (remote_port_low_i),
    .remote_port_high_i (remote_port_high_i),
    .local_port_low_i   (local_port_low_i),
    .local_port_high_i  (local_port_high_i),
    .tos_value_i        (tos_value_i),
    .tos_mask_i         (tos_mask_i),
    .matched_o          (matched_o),
    .filter_index_o     (filter_index_o),
    .table_full_o       (table_full_o)
  );

endmodule

`default_nettype wire
